FILE: hw/rtl/humidity_fan_controller_macros.svh
// Assertion helpers shared by the RTL; they sample on clock and are off in reset.
`ifndef HUMIDITY_FAN_CONTROLLER_MACROS_SVH
`define HUMIDITY_FAN_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HFC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/hfc_pkg.sv
package hfc_pkg;

   // Field widths
   localparam int HUM_BITS     = 10;
   localparam int ERR_BITS     = 4;
   localparam int TIMEOUT_BITS = 20;
   localparam int LIMIT_BITS   = 4;

   // Press age counter width and the width used to compare it with the timeout
   localparam int TIMER_BITS = 20;
   localparam int CMP_BITS   = (TIMER_BITS > TIMEOUT_BITS) ? TIMER_BITS : TIMEOUT_BITS;
   localparam logic [TIMER_BITS-1:0] AGE_MAX = '1;

   // Reset values
   localparam logic [HUM_BITS-1:0]     BASE_RESET       = 10'd999;
   localparam logic [HUM_BITS-1:0]     ON_OFFSET_RESET  = 10'd350;
   localparam logic [HUM_BITS-1:0]     OFF_OFFSET_RESET = 10'd50;
   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET    = 20'd300000;
   localparam logic [LIMIT_BITS-1:0]   LIMIT_RESET      = 4'd5;
   localparam logic [ERR_BITS-1:0]     ERR_MAX          = '1;

   // CSR port
   localparam int ADDR_BITS = 4;
   localparam int DATA_BITS = 32;

   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_BUTTON = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_ON_OFFSET      = 2'd0,
      REG_OFF_OFFSET     = 2'd1,
      REG_MANUAL_TIMEOUT = 2'd2,
      REG_ERROR_LIMIT    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [HUM_BITS-1:0]     on_offset;
      logic [HUM_BITS-1:0]     off_offset;
      logic [TIMEOUT_BITS-1:0] manual_timeout;
      logic [LIMIT_BITS-1:0]   error_limit;
   } cfg_type;

   typedef struct packed {
      kind_type            kind;
      logic [HUM_BITS-1:0] humidity;
      logic                read_ok;
   } item_type;

   typedef struct packed {
      logic                fan_on;
      logic                manual_active;
      logic [HUM_BITS-1:0] baseline_level;
      logic [ERR_BITS-1:0] fail_count;
      logic                restarted;
   } result_type;

endpackage

FILE: hw/rtl/humidity_fan_controller.sv
// Humidity fan controller: drives a fan relay from a stream of requests (ticks,
// humidity samples in tenths of a percent, button presses) and returns one
// status word per request. It accepts one request per clock cycle unless a
// stalled response holds both registers; each request is first captured in an
// input register, then its state update and result are computed combinationally
// and written to the result register once it is free. The result register
// keeps taking requests while an earlier response waits, as long as the
// response is taken in the same cycle. Offsets, timeout and error limit sit in
// the CSR port (byte addresses 0, 4, 8, 12); they must be written only while
// the block is idle, which it does not enforce. No clearing pass follows reset.
`include "humidity_fan_controller_macros.svh"

module humidity_fan_controller import hfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // [9:0] humidity, [10] read_ok, rest zero
   input  logic [1:0]           req_tuser,   // [1:0] kind
   // response stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // [0] fan_on, [1] manual_active,
                                             // [11:2] baseline_level, [15:12] fail_count,
                                             // [16] restarted, rest zero
   // configuration
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   cfg_type    cfg;
   item_type   in_item_ff;
   logic       in_vld_ff, in_vld_in;
   result_type out_res_ff;
   result_type next_res;
   logic       out_vld_ff, out_vld_in;
   logic       advance;
   logic       req_take;

   hfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hfc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .item   (in_item_ff),
      .result (next_res)
   );

   // Handshake: the input register moves on when the result register is free
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_tready);

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.kind     <= kind_type'(req_tuser);
         in_item_ff.humidity <= req_tdata[HUM_BITS-1:0];
         in_item_ff.read_ok  <= req_tdata[HUM_BITS];
      end
      if (advance) begin
         out_res_ff <= next_res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, out_res_ff.restarted, out_res_ff.fail_count,
                        out_res_ff.baseline_level, out_res_ff.manual_active,
                        out_res_ff.fan_on};

   `HFC_ASSERT_NEXT(a_stall_holds, out_vld_ff && !rsp_tready, out_vld_ff && $stable(out_res_ff), "response changed while stalled")
   `HFC_ASSERT_NOW(a_full_blocks, in_vld_ff && out_vld_ff && !rsp_tready, !req_tready, "request taken with both stages full")
   `HFC_ASSERT_NEXT(a_advance_fills, advance, out_vld_ff, "advanced request lost")

endmodule

FILE: hw/rtl/hfc_csr.sv
module hfc_csr import hfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready,
   output cfg_type              cfg
);

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_offset      <= ON_OFFSET_RESET;
         cfg_ff.off_offset     <= OFF_OFFSET_RESET;
         cfg_ff.manual_timeout <= TIMEOUT_RESET;
         cfg_ff.error_limit    <= LIMIT_RESET;
      end else if (wr_en) begin
         case (index)
            REG_ON_OFFSET:      cfg_ff.on_offset      <= csr_pwdata[HUM_BITS-1:0];
            REG_OFF_OFFSET:     cfg_ff.off_offset     <= csr_pwdata[HUM_BITS-1:0];
            REG_MANUAL_TIMEOUT: cfg_ff.manual_timeout <= csr_pwdata[TIMEOUT_BITS-1:0];
            REG_ERROR_LIMIT:    cfg_ff.error_limit    <= csr_pwdata[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      case (index)
         REG_ON_OFFSET:      csr_prdata = DATA_BITS'(cfg_ff.on_offset);
         REG_OFF_OFFSET:     csr_prdata = DATA_BITS'(cfg_ff.off_offset);
         REG_MANUAL_TIMEOUT: csr_prdata = DATA_BITS'(cfg_ff.manual_timeout);
         REG_ERROR_LIMIT:    csr_prdata = DATA_BITS'(cfg_ff.error_limit);
         default:            csr_prdata = '0;
      endcase
   end

endmodule

FILE: hw/rtl/hfc_core.sv
`include "humidity_fan_controller_macros.svh"

module hfc_core import hfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  item_type   item,
   output result_type result
);

   logic                  relay_ff, relay_in;
   logic                  button_ff, button_in;
   logic                  by_button_ff, by_button_in;
   logic [HUM_BITS-1:0]   level_ff, level_in;
   logic                  level_good_ff, level_good_in;
   logic [HUM_BITS-1:0]   min_ff, min_in;
   logic [ERR_BITS-1:0]   err_ff, err_in;
   logic [TIMER_BITS-1:0] age_ff, age_in;
   logic                  restart;

   // Next state for one item, then manual timeout, relay evaluation and restart
   always_comb begin
      logic [HUM_BITS:0] on_level;
      logic [HUM_BITS:0] off_level;
      logic              level_high;
      logic              level_low;

      relay_in      = relay_ff;
      button_in     = button_ff;
      by_button_in  = by_button_ff;
      level_in      = level_ff;
      level_good_in = level_good_ff;
      min_in        = min_ff;
      err_in        = err_ff;
      age_in        = age_ff;
      restart       = 1'b0;

      case (item.kind)
         KIND_TICK: begin
            if (age_ff != AGE_MAX) age_in = age_ff + 1'b1;
         end
         KIND_SAMPLE: begin
            if (item.read_ok) begin
               level_in      = item.humidity;
               level_good_in = 1'b1;
               if (item.humidity != '0 && item.humidity < min_ff) min_in = item.humidity;
               err_in        = '0;
            end else begin
               level_good_in = 1'b0;
               if (err_ff != ERR_MAX) err_in = err_ff + 1'b1;
               restart = (err_in >= cfg.error_limit);
            end
         end
         KIND_BUTTON: begin
            if (button_ff) begin
               button_in = 1'b0;
            end else begin
               button_in = 1'b1;
               age_in    = '0;
            end
         end
         default: ;
      endcase

      // manual run timeout
      if (CMP_BITS'(age_in) > CMP_BITS'(cfg.manual_timeout)) button_in = 1'b0;

      // hysteresis relay
      on_level   = {1'b0, min_in} + {1'b0, cfg.on_offset};
      off_level  = {1'b0, min_in} + {1'b0, cfg.off_offset};
      level_high = level_good_in && ({1'b0, level_in} >= on_level);
      level_low  = level_good_in && ({1'b0, level_in} <= off_level);
      if (level_high || button_in) begin
         relay_in = 1'b1;
         if (button_in) by_button_in = 1'b1;
      end
      if ((level_low && !button_in) || (!button_in && by_button_in)) begin
         relay_in     = 1'b0;
         by_button_in = 1'b0;
      end

      // error limit reached: everything back to reset
      if (restart) begin
         relay_in      = 1'b0;
         button_in     = 1'b0;
         by_button_in  = 1'b0;
         level_in      = '0;
         level_good_in = 1'b1;
         min_in        = BASE_RESET;
         err_in        = '0;
         age_in        = '0;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff      <= 1'b0;
         button_ff     <= 1'b0;
         by_button_ff  <= 1'b0;
         level_ff      <= '0;
         level_good_ff <= 1'b1;
         min_ff        <= BASE_RESET;
         err_ff        <= '0;
         age_ff        <= '0;
      end else if (step) begin
         relay_ff      <= relay_in;
         button_ff     <= button_in;
         by_button_ff  <= by_button_in;
         level_ff      <= level_in;
         level_good_ff <= level_good_in;
         min_ff        <= min_in;
         err_ff        <= err_in;
         age_ff        <= age_in;
      end
   end

   assign result.fan_on         = relay_in;
   assign result.manual_active  = button_in;
   assign result.baseline_level = min_in;
   assign result.fail_count     = err_in;
   assign result.restarted      = restart;

   `HFC_ASSERT_NEXT(a_restart_clears, step && restart, min_ff == BASE_RESET && err_ff == '0 && !relay_ff, "restart left state behind")
   `HFC_ASSERT_NEXT(a_good_read_clears_err, step && item.kind == KIND_SAMPLE && item.read_ok, err_ff == '0, "good read kept fail count")
   `HFC_ASSERT_NOW(a_manual_runs_fan, button_ff, relay_ff, "manual run active with fan off")
   `HFC_ASSERT_NOW(a_baseline_bound, 1'b1, min_ff <= BASE_RESET, "baseline above reset value")

endmodule
